### rtl/ebal_pkg.sv
// ----------------------------------------------------------------------------
// Extent bitmap allocator package
// Transfer payload types, command and status codes, register indexes and the
// small control groups passed between the allocator's modules.
// ----------------------------------------------------------------------------
package ebal_pkg;

   // Width of a configuration register and of the write data port.
   localparam int CFG_W = 13;

   // Command codes carried in the request field cmd.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_OWNED   = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_NOTSET  = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_TOTAL = 1'b0;
   localparam logic CSR_PREF  = 1'b1;

   // One request transfer.
   typedef struct packed {
      logic        cmd;
      logic [15:0] owner_id;
      logic [11:0] extent_id;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] extent_out;
      logic [12:0] stored_count;
   } rsp_type;

   // Enables of a memory with one read and one write port.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctrl_type;

   // Which edges of the current scan range fall into the word being checked.
   typedef struct packed {
      logic lo_en;
      logic hi_en;
   } scan_ctrl_type;

endpackage

### rtl/ebal_bitmap.sv
// ----------------------------------------------------------------------------
// Used-bit map memory with free-bit finder
// Holds the used bits in words, one read and one write port with a registered
// read, and searches the read word for its lowest clear bit inside the range.
// ----------------------------------------------------------------------------
module ebal_bitmap #(
   parameter int WORDS  = 64,
   parameter int WAW    = 6,
   parameter int LOG_WB = 6
) (
   input  logic                      clock,
   input  ebal_pkg::mem_ctrl_type    ctrl,
   input  logic [WAW-1:0]            rd_addr,
   input  logic [WAW-1:0]            wr_addr,
   input  logic [(1 << LOG_WB)-1:0]  wr_data,
   output logic [(1 << LOG_WB)-1:0]  rd_data,
   input  ebal_pkg::scan_ctrl_type   scan,
   input  logic [LOG_WB-1:0]         lo_off,
   input  logic [LOG_WB-1:0]         hi_off,
   output logic                      found,
   output logic [LOG_WB-1:0]         pos
);
   import ebal_pkg::*;

   localparam int WB = 1 << LOG_WB;

   logic [WB-1:0] mem_ff [WORDS];
   logic [WB-1:0] rd_data_ff;
   logic [WB-1:0] masked;

   // Synchronous memory, read data registered.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // Bits below the range start or above its last bit count as used.
   always_comb begin
      for (int j = 0; j < WB; j++) begin
         masked[j] = rd_data_ff[j]
                     | (scan.lo_en && (LOG_WB'(j) < lo_off))
                     | (scan.hi_en && (LOG_WB'(j) > hi_off));
      end
   end

   // Lowest clear bit of the masked word.
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (!masked[j]) begin
            found = 1'b1;
            pos   = LOG_WB'(j);
         end
      end
   end

endmodule

### rtl/ebal_owner.sv
// ----------------------------------------------------------------------------
// Owner table memory
// One owner number per extent, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module ebal_owner #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int OW    = 16
) (
   input  logic                   clock,
   input  ebal_pkg::mem_ctrl_type ctrl,
   input  logic [AW-1:0]          rd_addr,
   input  logic [AW-1:0]          wr_addr,
   input  logic [OW-1:0]          wr_data,
   output logic [OW-1:0]          rd_data
);
   import ebal_pkg::*;

   logic [OW-1:0] mem_ff [DEPTH];
   logic [OW-1:0] rd_data_ff;

   // Synchronous memory, read data registered.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/extent_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Extent bitmap allocator
// Next-fit allocation and release of fixed-size extents from a used-bit map
// with a preferred region and a per-extent owner table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every owner table entry
// and bitmap word, with busy high; configuration writes are taken
// during it. One request is worked on at a time and busy stays high until its
// result has been produced. A free checks the extent against the map size and,
// if it lies inside, reads the word holding its bit and then clears owner and
// bit; an extent outside the map is answered at the check. An allocate is
// paced by the bitmap scan, which reads one 64-bit word per cycle from the
// bitmap memory; it takes longest when the preferred region and then
// the whole map must both be searched with a wrap. The result is shown on
// rsp_payload for exactly one cycle with rsp_valid high and cannot be held
// off; a new request may be started in that same cycle.
// ----------------------------------------------------------------------------
module extent_bitmap_allocator #(
   parameter int MAX_EXTENTS = 4096,
   parameter int OWNER_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  ebal_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   output ebal_pkg::rsp_type              rsp_payload,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [ebal_pkg::CFG_W-1:0]     csr_wdata
);
   import ebal_pkg::*;

   // Address and width derivations.
   localparam int AW     = $clog2(MAX_EXTENTS);
   localparam int TW     = $clog2(MAX_EXTENTS + 1);
   localparam int LOG_WB = ($clog2(MAX_EXTENTS) - 1 < 6) ? $clog2(MAX_EXTENTS) - 1 : 6;
   localparam int WB     = 1 << LOG_WB;
   localparam int NWORDS = (MAX_EXTENTS + WB - 1) / WB;
   localparam int WAW    = $clog2(NWORDS);
   localparam int PW     = WAW + LOG_WB;
   localparam int RW     = PW + 1;
   localparam int XW     = (RW > 12) ? RW : 12;

   // Scan phases of an allocate, in search order.
   localparam logic [2:0] PH_PREF_FWD  = 3'd0;
   localparam logic [2:0] PH_PREF_WRAP = 3'd1;
   localparam logic [2:0] PH_FULL_FWD  = 3'd2;
   localparam logic [2:0] PH_FULL_WRAP = 3'd3;
   localparam logic [2:0] PH_DONE      = 3'd4;

   typedef enum logic [7:0] {
      S_CLEAR    = 8'b0000_0001,
      S_IDLE     = 8'b0000_0010,
      S_PHASE    = 8'b0000_0100,
      S_SCAN     = 8'b0000_1000,
      S_OWN_RD   = 8'b0001_0000,
      S_ALLOC_WR = 8'b0010_0000,
      S_FREE_CHK = 8'b0100_0000,
      S_FREE_WR  = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   req_type             req_ff, req_in;
   logic [RW-1:0]       t_ff, t_in;
   logic [RW-1:0]       p_ff, p_in;
   logic [2:0]          phase_ff, phase_in;
   logic [RW-1:0]       lo_ff, lo_in;
   logic [RW-1:0]       hi_ff, hi_in;
   logic [WAW-1:0]      lo_word_ff, lo_word_in;
   logic [WAW-1:0]      last_ff, last_in;
   logic [LOG_WB-1:0]   lo_off_ff, lo_off_in;
   logic [LOG_WB-1:0]   hi_off_ff, hi_off_in;
   logic [WAW-1:0]      issue_ff, issue_in;
   logic                iss_on_ff, iss_on_in;
   logic                pend_ff, pend_in;
   logic [WAW-1:0]      pend_addr_ff, pend_addr_in;
   logic [PW-1:0]       bit_ff, bit_in;
   logic [WB-1:0]       word_ff, word_in;
   logic [AW-1:0]       id_ff, id_in;
   logic [PW-1:0]       nsp_ff, nsp_in;
   logic [TW-1:0]       cnt_ff, cnt_in;
   logic [CFG_W-1:0]    csr_total_ff, csr_total_in;
   logic [CFG_W-1:0]    csr_pref_ff, csr_pref_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Memory port signals.
   mem_ctrl_type        bm_ctrl;
   logic [WAW-1:0]      bm_rd_addr;
   logic [WAW-1:0]      bm_wr_addr;
   logic [WB-1:0]       bm_wr_data;
   logic [WB-1:0]       bm_rd_data;
   scan_ctrl_type       bm_scan;
   logic                bm_found;
   logic [LOG_WB-1:0]   bm_pos;
   mem_ctrl_type        own_ctrl;
   logic [AW-1:0]       own_rd_addr;
   logic [AW-1:0]       own_wr_addr;
   logic [OWNER_BITS-1:0] own_wr_data;
   logic [OWNER_BITS-1:0] own_rd_data;

   // Derived values.
   logic [RW-1:0]       eff_t;
   logic [RW-1:0]       eff_p;
   logic [RW-1:0]       s_pos;
   logic [RW-1:0]       s_min_t;
   logic                ph_en;
   logic [RW-1:0]       ph_lo;
   logic [RW-1:0]       ph_hi;
   logic [RW-1:0]       ph_hi_m1;
   logic [RW-1:0]       alloc_id;
   logic [XW-1:0]       free_id_x;
   logic [XW-1:0]       free_t_x;
   logic [XW-1:0]       free_bit_x;
   logic [WB-1:0]       bit_onehot;
   logic [TW-1:0]       cnt_inc;
   logic [TW-1:0]       cnt_dec;

   // Bitmap and owner memories.
   ebal_bitmap #(
      .WORDS  (NWORDS),
      .WAW    (WAW),
      .LOG_WB (LOG_WB)
   ) u_bitmap (
      .clock   (clock),
      .ctrl    (bm_ctrl),
      .rd_addr (bm_rd_addr),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_data (bm_rd_data),
      .scan    (bm_scan),
      .lo_off  (lo_off_ff),
      .hi_off  (hi_off_ff),
      .found   (bm_found),
      .pos     (bm_pos)
   );

   ebal_owner #(
      .DEPTH (MAX_EXTENTS),
      .AW    (AW),
      .OW    (OWNER_BITS)
   ) u_owner (
      .clock   (clock),
      .ctrl    (own_ctrl),
      .rd_addr (own_rd_addr),
      .wr_addr (own_wr_addr),
      .wr_data (own_wr_data),
      .rd_data (own_rd_data)
   );

   // Effective total and preferred limit from the configuration registers.
   always_comb begin
      if (32'(csr_total_ff) > MAX_EXTENTS) begin
         eff_t = RW'(MAX_EXTENTS);
      end else begin
         eff_t = RW'(csr_total_ff);
      end
      if (32'(csr_pref_ff) > 32'(eff_t)) begin
         eff_p = eff_t;
      end else begin
         eff_p = RW'(csr_pref_ff);
      end
   end

   // Range of the current scan phase. The wrap phases only cover the part
   // below the start, since the forward phase already found it all used.
   always_comb begin
      s_pos   = RW'(nsp_ff);
      s_min_t = (s_pos < t_ff) ? s_pos : t_ff;
      ph_en   = 1'b0;
      ph_lo   = '0;
      ph_hi   = '0;
      unique case (phase_ff)
         PH_PREF_FWD: begin
            ph_en = (s_pos < p_ff);
            ph_lo = s_pos;
            ph_hi = p_ff;
         end
         PH_PREF_WRAP: begin
            ph_en = (s_pos < p_ff) && (s_pos != '0);
            ph_hi = s_pos;
         end
         PH_FULL_FWD: begin
            ph_en = (p_ff < t_ff);
            ph_lo = s_min_t;
            ph_hi = t_ff;
         end
         PH_FULL_WRAP: begin
            ph_en = (p_ff < t_ff) && (s_pos != '0);
            ph_hi = s_min_t;
         end
         default: begin
            ph_en = 1'b0;
         end
      endcase
      ph_en    = ph_en && (ph_lo < ph_hi);
      ph_hi_m1 = ph_hi - RW'(1);
   end

   // Extent numbers, bit positions and count updates.
   always_comb begin
      alloc_id   = t_ff - RW'(1) - RW'(bit_ff);
      free_id_x  = XW'(req_ff.extent_id);
      free_t_x   = XW'(t_ff);
      free_bit_x = free_t_x - XW'(1) - free_id_x;
      bit_onehot = WB'(1) << bit_ff[LOG_WB-1:0];
      cnt_inc    = (cnt_ff < TW'(MAX_EXTENTS)) ? cnt_ff + TW'(1) : cnt_ff;
      cnt_dec    = (cnt_ff != '0) ? cnt_ff - TW'(1) : cnt_ff;
      bm_scan.lo_en = (pend_addr_ff == lo_word_ff);
      bm_scan.hi_en = (pend_addr_ff == last_ff);
   end

   // Configuration writes.
   always_comb begin
      csr_total_in = csr_total_ff;
      csr_pref_in  = csr_pref_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL: csr_total_in = csr_wdata;
            CSR_PREF:  csr_pref_in  = csr_wdata;
            default:   csr_total_in = csr_total_ff;
         endcase
      end
   end

   // Sequencer: clearing pass, scan phases and read-modify-write of both maps.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      phase_in     = phase_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo_word_in   = lo_word_ff;
      last_in      = last_ff;
      lo_off_in    = lo_off_ff;
      hi_off_in    = hi_off_ff;
      issue_in     = issue_ff;
      iss_on_in    = iss_on_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      bit_in       = bit_ff;
      word_in      = word_ff;
      id_in        = id_ff;
      nsp_in       = nsp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      bm_ctrl      = '0;
      bm_rd_addr   = issue_ff;
      bm_wr_addr   = bit_ff[PW-1:LOG_WB];
      bm_wr_data   = '0;
      own_ctrl     = '0;
      own_rd_addr  = alloc_id[AW-1:0];
      own_wr_addr  = id_ff;
      own_wr_data  = '0;

      unique case (state_ff)
         // Zero one owner entry per cycle, plus one bitmap word while words remain.
         S_CLEAR: begin
            own_ctrl.wr_en = 1'b1;
            own_wr_addr    = clr_ff;
            if (32'(clr_ff) < NWORDS) begin
               bm_ctrl.wr_en = 1'b1;
               bm_wr_addr    = WAW'(clr_ff);
            end
            if (clr_ff == AW'(MAX_EXTENTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         S_IDLE: begin
            if (start) begin
               req_in   = req_payload;
               t_in     = eff_t;
               p_in     = eff_p;
               phase_in = PH_PREF_FWD;
               if (req_payload.cmd == CMD_FREE) begin
                  state_in = S_FREE_CHK;
               end else begin
                  state_in = S_PHASE;
               end
            end
         end

         // Set up the next non-empty scan range, or report no space.
         S_PHASE: begin
            pend_in = 1'b0;
            if (phase_ff == PH_DONE) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = ST_NOSPACE;
               rsp_in.extent_out   = '0;
               rsp_in.stored_count = 13'(cnt_ff);
               state_in            = S_IDLE;
            end else begin
               phase_in = phase_ff + 3'd1;
               if (ph_en) begin
                  lo_in      = ph_lo;
                  hi_in      = ph_hi;
                  lo_word_in = ph_lo[PW-1:LOG_WB];
                  last_in    = ph_hi_m1[PW-1:LOG_WB];
                  lo_off_in  = ph_lo[LOG_WB-1:0];
                  hi_off_in  = ph_hi_m1[LOG_WB-1:0];
                  issue_in   = ph_lo[PW-1:LOG_WB];
                  iss_on_in  = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end

         // One word read per cycle; the word read last cycle is checked.
         S_SCAN: begin
            bm_ctrl.rd_en = iss_on_ff;
            bm_rd_addr    = issue_ff;
            if (iss_on_ff) begin
               if (issue_ff == last_ff) begin
                  iss_on_in = 1'b0;
               end else begin
                  issue_in = issue_ff + WAW'(1);
               end
            end
            pend_in      = iss_on_ff;
            pend_addr_in = issue_ff;
            if (pend_ff && bm_found) begin
               bit_in   = {pend_addr_ff, bm_pos};
               word_in  = bm_rd_data;
               state_in = S_OWN_RD;
            end else if (pend_ff && (pend_addr_ff == last_ff)) begin
               state_in = S_PHASE;
            end
         end

         S_OWN_RD: begin
            own_ctrl.rd_en = 1'b1;
            id_in          = alloc_id[AW-1:0];
            state_in       = S_ALLOC_WR;
         end

         // Take the extent unless an owner is still recorded for it.
         S_ALLOC_WR: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (own_rd_data != '0) begin
               rsp_in.status       = ST_OWNED;
               rsp_in.extent_out   = '0;
               rsp_in.stored_count = 13'(cnt_ff);
            end else begin
               bm_ctrl.wr_en       = 1'b1;
               bm_wr_data          = word_ff | bit_onehot;
               own_ctrl.wr_en      = 1'b1;
               own_wr_data         = OWNER_BITS'(req_ff.owner_id);
               nsp_in              = bit_ff;
               cnt_in              = cnt_inc;
               rsp_in.status       = ST_OK;
               rsp_in.extent_out   = 12'(id_ff);
               rsp_in.stored_count = 13'(cnt_inc);
            end
         end

         // Range check, then read the word holding the extent's bit.
         S_FREE_CHK: begin
            if (free_id_x >= free_t_x) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = ST_INVALID;
               rsp_in.extent_out   = '0;
               rsp_in.stored_count = 13'(cnt_ff);
               state_in            = S_IDLE;
            end else begin
               bit_in        = free_bit_x[PW-1:0];
               id_in         = AW'(free_id_x);
               bm_ctrl.rd_en = 1'b1;
               bm_rd_addr    = free_bit_x[PW-1:LOG_WB];
               state_in      = S_FREE_WR;
            end
         end

         // Clear owner and bit; pull the search position into the region.
         S_FREE_WR: begin
            own_ctrl.wr_en      = 1'b1;
            cnt_in              = cnt_dec;
            rsp_valid_in        = 1'b1;
            rsp_in.stored_count = 13'(cnt_dec);
            state_in            = S_IDLE;
            if (bm_rd_data[bit_ff[LOG_WB-1:0]]) begin
               bm_ctrl.wr_en     = 1'b1;
               bm_wr_data        = bm_rd_data & ~bit_onehot;
               rsp_in.status     = ST_OK;
               rsp_in.extent_out = 12'(id_ff);
               if ((RW'(nsp_ff) >= p_ff) && (RW'(bit_ff) < p_ff)) begin
                  nsp_in = bit_ff;
               end
            end else begin
               rsp_in.status     = ST_NOTSET;
               rsp_in.extent_out = '0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= PH_PREF_FWD;
         iss_on_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         nsp_ff       <= '0;
         cnt_ff       <= '0;
         csr_total_ff <= CFG_W'(4096);
         csr_pref_ff  <= CFG_W'(4096);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         phase_ff     <= phase_in;
         iss_on_ff    <= iss_on_in;
         pend_ff      <= pend_in;
         nsp_ff       <= nsp_in;
         cnt_ff       <= cnt_in;
         csr_total_ff <= csr_total_in;
         csr_pref_ff  <= csr_pref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      lo_word_ff   <= lo_word_in;
      last_ff      <= last_in;
      lo_off_ff    <= lo_off_in;
      hi_off_ff    <= hi_off_in;
      issue_ff     <= issue_in;
      pend_addr_ff <= pend_addr_in;
      bit_ff       <= bit_in;
      word_ff      <= word_in;
      id_ff        <= id_in;
      rsp_ff       <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A result transfer only follows work on a request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a request in progress");

   // An accepted request makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // A found bit lies inside the range of the scan that found it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_WR) |-> ((RW'(bit_ff) >= lo_ff) && (RW'(bit_ff) < hi_ff)))
      else $error("allocated bit outside the scanned range");

   // The stored-extent count never passes its saturation value.
   assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_EXTENTS)
      else $error("stored count above the extent count");

endmodule

### verif/tb_extent_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent bitmap allocator testbench
// Drives allocate and free requests through the start/busy handshake and
// checks every result against an in-bench model of the used-bit map, the
// owner table, the next-fit search position and the stored-extent count.
// A short directed sequence hits the corner cases. Random phases then follow,
// each with its own total and preferred sizes.
// ----------------------------------------------------------------------------
module tb_extent_bitmap_allocator;
   import ebal_pkg::*;

   localparam int MAP_SIZE    = 4096;
   localparam int RANDOM_REQS = 600;
   localparam int QUIET_TAIL  = 80;
   localparam int CYCLE_LIMIT = 600000;
   localparam int END_WAIT    = 200;

   // One awaited result, tagged with whether it answers an allocate.
   typedef struct packed {
      logic    is_alloc;
      rsp_type rsp;
   } awaited_result_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_type          req_payload = '0;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_we      = 1'b0;
   logic             csr_index   = CSR_TOTAL;
   logic [CFG_W-1:0] csr_wdata   = '0;

   extent_bitmap_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Allocator model state and its copy of the registers.
   bit               used_bits [MAP_SIZE];
   bit [15:0]        owners [MAP_SIZE];
   int               search_pos = 0;
   int               held_count = 0;
   logic [CFG_W-1:0] cfg_total  = 13'd4096;
   logic [CFG_W-1:0] cfg_pref   = 13'd4096;

   req_type            pending_reqs [$];
   awaited_result_type expected_results [$];
   logic [11:0]        live_ids [$];
   awaited_result_type next_outcome;
   awaited_result_type head;
   int               outstanding   = 0;
   int               queued_total  = 0;
   int               settings_used = 0;
   int               error_count   = 0;
   int               status_hits [8];
   int               idle_rate     = 0;
   int               gap_left      = 0;
   int               cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // First clear bit in [lo, hi), or hi when there is none.
   function automatic int find_clear(int lo, int hi);
      for (int b = lo; b < hi; b++)
         if (!used_bits[b])
            return b;
      return hi;
   endfunction

   // Next-fit scan below limit from a start position, wrapping to zero once.
   // Sets the bit it finds; -1 when the range is full.
   function automatic int claim_bit(int limit, int from);
      int b;
      b = find_clear((from < limit) ? from : limit, limit);
      if (b == limit) begin
         if (from == 0)
            return -1;
         b = find_clear(0, limit);
         if (b == limit)
            return -1;
      end
      used_bits[b] = 1'b1;
      return b;
   endfunction

   // Applies one request to the model and returns the result it must give.
   function automatic rsp_type allocator_step(req_type r);
      int      t;
      int      p;
      int      b;
      int      id;
      rsp_type o;
      t = (cfg_total > MAP_SIZE) ? MAP_SIZE : int'(cfg_total);
      p = (cfg_pref > t) ? t : int'(cfg_pref);
      o.status = ST_OK;
      o.extent_out = '0;
      b = -1;
      if (r.cmd == CMD_ALLOC) begin
         // Preferred region first, then the whole map if it is larger.
         if (search_pos < p)
            b = claim_bit(p, search_pos);
         if (b < 0 && p < t)
            b = claim_bit(t, search_pos);
         if (b < 0) begin
            o.status = ST_NOSPACE;
         end else begin
            id = t - b - 1;
            if (owners[id] != 0) begin
               // Still owned: give the bit back and refuse.
               used_bits[b] = 1'b0;
               o.status = ST_OWNED;
            end else begin
               owners[id] = r.owner_id;
               search_pos = b;
               if (held_count < MAP_SIZE)
                  held_count++;
               o.extent_out = 12'(id);
            end
         end
      end else begin
         id = int'(r.extent_id);
         if (id >= t) begin
            o.status = ST_INVALID;
         end else begin
            b = t - id - 1;
            owners[id] = '0;
            if (!used_bits[b]) begin
               o.status = ST_NOTSET;
            end else begin
               used_bits[b] = 1'b0;
               // A free inside the preferred region pulls the search back.
               if (search_pos >= p && b < p)
                  search_pos = b;
               o.extent_out = 12'(id);
            end
            if (held_count > 0)
               held_count--;
         end
      end
      o.stored_count = 13'(held_count);
      return o;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic queue_req(input logic cmd, input logic [15:0] owner,
                            input logic [11:0] ext);
      req_type r;
      r.cmd = cmd;
      r.owner_id = owner;
      r.extent_id = ext;
      pending_reqs.push_back(r);
      queued_total++;
      outstanding++;
   endtask

   // Waits until every queued request has produced its result.
   task automatic settle();
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_TOTAL)
         cfg_total = value;
      else
         cfg_pref = value;
   endtask

   // Request driver: takes the next item on an accepting edge or when idle,
   // with random bursts of idle cycles between transfers.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            next_outcome.is_alloc = (req_payload.cmd == CMD_ALLOC);
            next_outcome.rsp = allocator_step(req_payload);
            expected_results.push_back(next_outcome);
         end
         if (!start || !busy) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               start    <= 1'b0;
            end else if (pending_reqs.size() != 0 && idle_rate != 0 &&
                         $urandom_range(0, 7) < idle_rate) begin
               gap_left <= $urandom_range(0, 5);
               start    <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               start       <= 1'b1;
               req_payload <= pending_reqs.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every strobed result is compared with the oldest
   // expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         status_hits[rsp_payload.status]++;
         if (expected_results.size() == 0) begin
            flag_error($sformatf("result with nothing expected: status %0d extent %0d",
                                 rsp_payload.status, rsp_payload.extent_out));
         end else begin
            head = expected_results.pop_front();
            outstanding--;
            if (rsp_payload.status !== head.rsp.status)
               flag_error($sformatf("status %0d, expected %0d",
                                    rsp_payload.status, head.rsp.status));
            if (rsp_payload.extent_out !== head.rsp.extent_out)
               flag_error($sformatf("extent_out %0d, expected %0d",
                                    rsp_payload.extent_out, head.rsp.extent_out));
            if (rsp_payload.stored_count !== head.rsp.stored_count)
               flag_error($sformatf("stored_count %0d, expected %0d",
                                    rsp_payload.stored_count, head.rsp.stored_count));
            if (head.is_alloc && head.rsp.status == ST_OK)
               live_ids.push_back(head.rsp.extent_out);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stimulus: reset, directed corner cases, then random phases.
   initial begin
      int               pick;
      int               batches;
      int               n;
      int               alloc_pct;
      int               idx;
      int               eff;
      int               random_end;
      logic [CFG_W-1:0] total;
      logic [CFG_W-1:0] pref;
      logic [11:0]      ext;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Default sizes: owner extremes, owner zero, double free, count
      // saturating at zero, free of a clear bit.
      write_csr(CSR_TOTAL, 13'd4096);
      write_csr(CSR_PREF, 13'd4096);
      settings_used++;
      queue_req(CMD_ALLOC, 16'hFFFF, 12'hFFF);
      queue_req(CMD_ALLOC, 16'h0000, 12'h000);
      queue_req(CMD_FREE, 16'h5A5A, 12'd4094);
      queue_req(CMD_FREE, 16'h0000, 12'd4094);
      queue_req(CMD_FREE, 16'hFFFF, 12'd4095);
      queue_req(CMD_FREE, 16'h1234, 12'd0);
      settle();

      // Build an extent whose owner survives while its bit is clear by
      // shrinking the map under it, then allocate onto it.
      write_csr(CSR_TOTAL, 13'd2);
      write_csr(CSR_PREF, 13'd2);
      queue_req(CMD_ALLOC, 16'h0001, 12'hABC);
      queue_req(CMD_ALLOC, 16'h8000, 12'h543);
      settle();
      write_csr(CSR_TOTAL, 13'd1);
      write_csr(CSR_PREF, 13'd1);
      queue_req(CMD_FREE, 16'hFFFF, 12'd0);
      settle();
      write_csr(CSR_TOTAL, 13'd2);
      write_csr(CSR_PREF, 13'd2);
      queue_req(CMD_ALLOC, 16'h00AA, 12'h000);
      settle();

      // Empty map: no space on allocate, invalid on free.
      write_csr(CSR_TOTAL, 13'd0);
      queue_req(CMD_ALLOC, 16'h1111, 12'h000);
      queue_req(CMD_FREE, 16'h0000, 12'd0);
      settle();

      // Sizes above the map saturate.
      write_csr(CSR_TOTAL, 13'h1FFF);
      write_csr(CSR_PREF, 13'h1FFF);
      queue_req(CMD_ALLOC, 16'h7FFF, 12'hFFF);
      queue_req(CMD_FREE, 16'h0000, 12'hFFF);
      settle();

      // Small map with a smaller preferred region: fill it past full, free
      // inside the region, free past the end.
      write_csr(CSR_TOTAL, 13'd4);
      write_csr(CSR_PREF, 13'd2);
      repeat (5) queue_req(CMD_ALLOC, 16'h0F0F, 12'h000);
      queue_req(CMD_FREE, 16'h0000, 12'd3);
      queue_req(CMD_FREE, 16'h0000, 12'd4);
      settle();

      // Empty preferred region: only the whole-map scan runs.
      write_csr(CSR_PREF, 13'd0);
      settings_used += 6;
      queue_req(CMD_ALLOC, 16'h0002, 12'h000);
      settle();

      random_end = queued_total + RANDOM_REQS;
      while (queued_total < random_end) begin
         // Pick the sizes for this phase.
         pick = $urandom_range(0, 19);
         if (pick == 0)
            total = '0;
         else if (pick <= 6)
            total = 13'($urandom_range(1, 16));
         else if (pick <= 13)
            total = 13'($urandom_range(17, 300));
         else if (pick <= 16)
            total = 13'd4096;
         else
            total = 13'($urandom_range(4097, 8191));
         eff = (total > MAP_SIZE) ? MAP_SIZE : int'(total);
         pick = $urandom_range(0, 9);
         if (pick < 3)
            pref = total;
         else if (pick < 5)
            pref = 13'($urandom_range(int'(total), 8191));
         else if (pick == 5 || eff == 0)
            pref = '0;
         else
            pref = 13'($urandom_range(1, eff));
         write_csr(CSR_TOTAL, total);
         write_csr(CSR_PREF, pref);
         settings_used++;
         live_ids.delete();

         batches = $urandom_range(2, 6);
         for (int k = 0; k < batches; k++) begin
            n = $urandom_range(1, 20);
            alloc_pct = $urandom_range(30, 90);
            idle_rate = (queued_total >= random_end - QUIET_TAIL) ? 0
                        : $urandom_range(0, 3);
            for (int j = 0; j < n; j++) begin
               if ($urandom_range(0, 99) < alloc_pct) begin
                  queue_req(CMD_ALLOC,
                            ($urandom_range(0, 19) == 0) ? 16'h0000 : 16'($urandom),
                            12'($urandom));
               end else begin
                  // Mostly frees of extents handed out in this phase.
                  if (live_ids.size() != 0 && $urandom_range(0, 9) < 7) begin
                     idx = $urandom_range(0, live_ids.size() - 1);
                     ext = live_ids[idx];
                     live_ids.delete(idx);
                  end else if ($urandom_range(0, 1) == 0) begin
                     ext = 12'($urandom_range(0, (eff < 4095) ? eff + 1 : 4095));
                  end else begin
                     ext = 12'($urandom);
                  end
                  queue_req(CMD_FREE, 16'($urandom), ext);
               end
            end
            settle();
         end
      end

      settle();
      repeat (END_WAIT) @(posedge clock);
      $display("Covered %0d requests across %0d size settings.",
               queued_total, settings_used);
      $display("Results: ok %0d, no space %0d, owned %0d, invalid %0d, not set %0d.",
               status_hits[ST_OK], status_hits[ST_NOSPACE], status_hits[ST_OWNED],
               status_hits[ST_INVALID], status_hits[ST_NOTSET]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
